// ----- hw/rtl/triangle_face_normal_defines.svh -----
// Assertion macros shared by the face normal unit.
// Included by the top level; depends on nothing else.
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH
// Same-cycle implication checked on every rising clock edge outside reset.
`define TFN_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TFN_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/tfn_pkg.sv -----
// Shared types and constants of the face normal unit.
// Used by the controller, the datapath and the top level.
`default_nettype none
package tfn_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int NORM_WIDTH      = 16;
    localparam int MAG_WIDTH       = 30;
    localparam int SUM_WIDTH       = 62;
    localparam int LEN_WIDTH       = 31;
    localparam int QUO_WIDTH       = 15;
    localparam int SQRT_STEPS      = 31;
    localparam int DIV_STEPS       = 15;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
    } tfn_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tfn_stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/tfn_ctrl.sv -----
// Controller: tracks the vertex phase, launches the datapath on the third
// vertex and sends the three copies of the normal. Depends on tfn_pkg.
`default_nettype none
module tfn_ctrl
    import tfn_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic           out_last,
    output tfn_cmd_t       cmd,
    input  tfn_stat_t      stat
);
    localparam logic [1:0] ST_IN   = 2'd0;
    localparam logic [1:0] ST_WORK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] copy_reg, copy_next;
    logic       acc;

    assign in_ready  = (state_reg == ST_IN);
    assign acc       = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_last  = (copy_reg == 2'd2);
    assign cmd.load_a = acc && (phase_reg == 2'd0);
    assign cmd.load_b = acc && (phase_reg == 2'd1);
    assign cmd.start  = acc && (phase_reg != 2'd0) && (phase_reg != 2'd1);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        copy_next  = copy_reg;
        unique case (state_reg)
            ST_IN: begin
                if (acc) begin
                    if (cmd.start) begin
                        phase_next = 2'd0;
                        state_next = ST_WORK;
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            ST_WORK: begin
                if (stat.done) begin
                    copy_next  = 2'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    copy_next = copy_reg + 2'd1;
                    if (copy_reg == 2'd2) state_next = ST_IN;
                end
            end
            default: state_next = ST_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IN;
            phase_reg <= 2'd0;
            copy_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            copy_reg  <= copy_next;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/tfn_datapath.sv -----
// Datapath: vertex store, edge vectors, cross product, normalizing shift,
// bit-serial square root and per-component divider. Depends on tfn_pkg.
`default_nettype none
module tfn_datapath
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  tfn_cmd_t                           cmd,
    output tfn_stat_t                          stat,
    input  wire logic signed [COORD_WIDTH-1:0] vx,
    input  wire logic signed [COORD_WIDTH-1:0] vy,
    input  wire logic signed [COORD_WIDTH-1:0] vz,
    output logic [NORM_WIDTH-1:0]              nx,
    output logic [NORM_WIDTH-1:0]              ny,
    output logic [NORM_WIDTH-1:0]              nz,
    output logic                               degenerate
);
    localparam int EW  = COORD_WIDTH + 1;
    localparam int SW  = (EW > 31) ? 31 : EW;      // edge width after shrink
    localparam int PW  = 2 * SW;                   // product width
    localparam int CW  = PW + 1;                   // cross width
    localparam int SHW = $clog2(CW + 1);

    localparam logic [3:0] P_IDLE  = 4'd0;
    localparam logic [3:0] P_SHR   = 4'd1;
    localparam logic [3:0] P_MUL1  = 4'd2;
    localparam logic [3:0] P_MUL2  = 4'd3;
    localparam logic [3:0] P_CROSS = 4'd4;
    localparam logic [3:0] P_NORM  = 4'd5;
    localparam logic [3:0] P_SQ    = 4'd6;
    localparam logic [3:0] P_SUM   = 4'd7;
    localparam logic [3:0] P_SQRT  = 4'd8;
    localparam logic [3:0] P_DIV   = 4'd9;
    localparam logic [3:0] P_DONE  = 4'd10;

    logic signed [COORD_WIDTH-1:0] a_reg [3];
    logic signed [COORD_WIDTH-1:0] b_reg [3];
    logic signed [EW-1:0]          v_reg [3];
    logic signed [EW-1:0]          w_reg [3];
    logic signed [PW-1:0]          p1_reg [3];
    logic signed [PW-1:0]          p2_reg [3];
    logic signed [CW-1:0]          c_reg [3];
    logic [CW-1:0]                 m_reg [3];
    logic [MAG_WIDTH-1:0]          n_reg [3];
    logic [SUM_WIDTH-1:0]          sq_reg [3];
    logic [SUM_WIDTH-1:0]          rem_reg;
    logic [LEN_WIDTH-1:0]          root_reg;
    logic [LEN_WIDTH+QUO_WIDTH:0]  dr_reg;
    logic [QUO_WIDTH-1:0]          q_reg;
    logic [1:0]                    comp_reg;
    logic [5:0]                    cnt_reg;
    logic [3:0]                    ph_reg;
    logic                          degen_reg;
    logic [NORM_WIDTH-1:0]         enc_reg [3];

    // Edge shrink: only wide coordinates can reach 2^30.
    logic [EW-1:0] vm [3], wm [3];
    logic [EW-1:0] vmax, wmax;
    logic [1:0]    vs, ws;
    logic signed [SW-1:0] vsh [3], wsh [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vm[i] = v_reg[i][EW-1] ? EW'(-v_reg[i]) : EW'(v_reg[i]);
            wm[i] = w_reg[i][EW-1] ? EW'(-w_reg[i]) : EW'(w_reg[i]);
        end
        vmax = (vm[0] > vm[1]) ? vm[0] : vm[1];
        vmax = (vmax > vm[2]) ? vmax : vm[2];
        wmax = (wm[0] > wm[1]) ? wm[0] : wm[1];
        wmax = (wmax > wm[2]) ? wmax : wm[2];
        vs = 2'd0;
        ws = 2'd0;
        if (EW > 31) begin
            if ((33'(vmax) >> 1) >= 33'h40000000) vs = 2'd2;
            else if (33'(vmax) >= 33'h40000000) vs = 2'd1;
            if ((33'(wmax) >> 1) >= 33'h40000000) ws = 2'd2;
            else if (33'(wmax) >= 33'h40000000) ws = 2'd1;
        end
        for (int i = 0; i < 3; i++) begin
            vsh[i] = v_reg[i][EW-1] ? -SW'(vm[i] >> vs) : SW'(vm[i] >> vs);
            wsh[i] = w_reg[i][EW-1] ? -SW'(wm[i] >> ws) : SW'(wm[i] >> ws);
        end
    end

    logic signed [SW-1:0] vr_reg [3], wr_reg [3];

    // Normalizing shift of the component magnitudes so that the largest lies in [2^29, 2^30).
    logic [CW-1:0] mmax;
    logic [SHW-1:0] lz;
    logic          left;
    always_comb begin
        mmax = (m_reg[0] > m_reg[1]) ? m_reg[0] : m_reg[1];
        mmax = (mmax > m_reg[2]) ? mmax : m_reg[2];
        lz = '0;
        for (int k = 0; k < CW; k++) begin
            if (mmax[k]) lz = SHW'(k);
        end
        left = (lz < SHW'(MAG_WIDTH - 1));
    end

    logic [SUM_WIDTH-1:0] trial;
    assign trial = SUM_WIDTH'({root_reg, 2'b01}) << (2 * cnt_reg);

    always_comb begin
        stat.busy = (ph_reg != P_IDLE);
        stat.done = (ph_reg == P_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= P_IDLE;
        end else begin
            unique case (ph_reg)
                P_IDLE:  if (cmd.start) ph_reg <= P_SHR;
                P_SHR:   ph_reg <= P_MUL1;
                P_MUL1:  ph_reg <= P_MUL2;
                P_MUL2:  ph_reg <= P_CROSS;
                P_CROSS: ph_reg <= P_NORM;
                P_NORM:  ph_reg <= degen_reg ? P_DONE : P_SQ;
                P_SQ:    ph_reg <= P_SUM;
                P_SUM:   ph_reg <= P_SQRT;
                P_SQRT:  if (cnt_reg == 6'd0) ph_reg <= P_DIV;
                P_DIV:   if (comp_reg == 2'd2 && cnt_reg == 6'(DIV_STEPS))
                             ph_reg <= P_DONE;
                P_DONE:  ph_reg <= P_IDLE;
                default: ph_reg <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_a) begin
            a_reg[0] <= vx; a_reg[1] <= vy; a_reg[2] <= vz;
        end
        if (cmd.load_b) begin
            b_reg[0] <= vx; b_reg[1] <= vy; b_reg[2] <= vz;
        end
        if (cmd.start) begin
            for (int i = 0; i < 3; i++) v_reg[i] <= EW'(b_reg[i]) - EW'(a_reg[i]);
            w_reg[0] <= EW'(vx) - EW'(a_reg[0]);
            w_reg[1] <= EW'(vy) - EW'(a_reg[1]);
            w_reg[2] <= EW'(vz) - EW'(a_reg[2]);
        end
        unique case (ph_reg)
            P_SHR: begin
                for (int i = 0; i < 3; i++) begin
                    vr_reg[i] <= vsh[i];
                    wr_reg[i] <= wsh[i];
                end
            end
            P_MUL1: begin
                p1_reg[0] <= vr_reg[1] * wr_reg[2];
                p1_reg[1] <= vr_reg[2] * wr_reg[0];
                p1_reg[2] <= vr_reg[0] * wr_reg[1];
            end
            P_MUL2: begin
                p2_reg[0] <= vr_reg[2] * wr_reg[1];
                p2_reg[1] <= vr_reg[0] * wr_reg[2];
                p2_reg[2] <= vr_reg[1] * wr_reg[0];
            end
            P_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    c_reg[i] <= CW'(p1_reg[i]) - CW'(p2_reg[i]);
                    m_reg[i] <= (CW'(p1_reg[i]) - CW'(p2_reg[i])) >= 0
                        ? CW'(p1_reg[i]) - CW'(p2_reg[i])
                        : CW'(p2_reg[i]) - CW'(p1_reg[i]);
                end
                degen_reg <= (p1_reg[0] == p2_reg[0]) && (p1_reg[1] == p2_reg[1])
                          && (p1_reg[2] == p2_reg[2]);
            end
            P_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    n_reg[i] <= left
                        ? MAG_WIDTH'(m_reg[i] << (SHW'(MAG_WIDTH - 1) - lz))
                        : MAG_WIDTH'(m_reg[i] >> (lz - SHW'(MAG_WIDTH - 1)));
                    enc_reg[i] <= '0;
                end
            end
            P_SQ: begin
                for (int i = 0; i < 3; i++)
                    sq_reg[i] <= SUM_WIDTH'(n_reg[i]) * SUM_WIDTH'(n_reg[i]);
            end
            P_SUM: begin
                rem_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                root_reg <= '0;
                cnt_reg  <= 6'(SQRT_STEPS - 1);
            end
            P_SQRT: begin
                // One result bit per cycle, most significant first.
                if (rem_reg >= trial) begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= {root_reg[LEN_WIDTH-2:0], 1'b1};
                end else begin
                    root_reg <= {root_reg[LEN_WIDTH-2:0], 1'b0};
                end
                if (cnt_reg == 6'd0) begin
                    // The first dividend already carries half the length for rounding.
                    comp_reg <= 2'd0;
                    dr_reg   <= (LEN_WIDTH+QUO_WIDTH+1)'(n_reg[0]) * 16384
                              + (LEN_WIDTH+QUO_WIDTH+1)'({root_reg[LEN_WIDTH-2:0],
                                  rem_reg >= trial} >> 1);
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
            P_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (cnt_reg == 6'(DIV_STEPS)) begin
                    enc_reg[comp_reg] <= c_reg[comp_reg][CW-1]
                        ? NORM_WIDTH'(-NORM_WIDTH'(q_reg)) : NORM_WIDTH'(q_reg);
                    comp_reg <= comp_reg + 2'd1;
                    cnt_reg  <= 6'd0;
                    q_reg    <= '0;
                    if (comp_reg != 2'd2)
                        dr_reg <= (LEN_WIDTH+QUO_WIDTH+1)'(n_reg[comp_reg + 2'd1]) * 16384
                                + (LEN_WIDTH+QUO_WIDTH+1)'(root_reg >> 1);
                end else begin
                    if ((dr_reg >> (QUO_WIDTH - 1 - 32'(cnt_reg)))
                        >= (LEN_WIDTH+QUO_WIDTH+1)'(root_reg)) begin
                        dr_reg <= dr_reg - ((LEN_WIDTH+QUO_WIDTH+1)'(root_reg)
                                  << (QUO_WIDTH - 1 - 32'(cnt_reg)));
                        q_reg  <= q_reg | (QUO_WIDTH'(1) << (QUO_WIDTH - 1 - 32'(cnt_reg)));
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            P_IDLE: begin
                q_reg   <= '0;
                cnt_reg <= 6'd0;
            end
            default: begin
            end
        endcase
    end

    assign nx = enc_reg[0];
    assign ny = enc_reg[1];
    assign nz = enc_reg[2];
    assign degenerate = degen_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/triangle_face_normal.sv -----
// Top level of the face normal unit: stream ports, controller, datapath.
// Depends on tfn_pkg, tfn_ctrl, tfn_datapath and the assertion macro header.
`default_nettype none
`include "triangle_face_normal_defines.svh"
// Vertices enter one word at a time, three to a face. The first two words of
// a face are taken and yield nothing. The third starts the datapath: edges,
// products, normalizing shift and squares, then the bit-serial square root,
// the restoring divider for each of the three components and a handover
// step, after which the first copy of the normal is valid. A degenerate face
// skips the squares, their sum, the root and the divider. The normal is then
// sent three times, last on the third word, and the next vertex is taken once
// the third copy has gone out.
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // vx, vy, vz from the lowest bit up
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // nx, ny, nz from the lowest bit up
    output logic [47:0]                     m_tdata,
    // degenerate
    output logic                            m_tuser,
    output logic                            m_tlast
);
    tfn_cmd_t  cmd;
    tfn_stat_t stat;
    logic [NORM_WIDTH-1:0] nx, ny, nz;

    tfn_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
        .cmd(cmd), .stat(stat)
    );

    tfn_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .vx(s_tdata[COORD_WIDTH-1:0]),
        .vy(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .vz(s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .nx(nx), .ny(ny), .nz(nz), .degenerate(m_tuser)
    );

    assign m_tdata = {nz, ny, nx};

    `TFN_ASSERT_IMP(a_no_in_while_out, aclk, aresetn, m_tvalid, !s_tready)
    `TFN_ASSERT_IMP(a_idle_while_out, aclk, aresetn, m_tvalid, !stat.busy)
    `TFN_ASSERT_NEXT(a_start_busy, aclk, aresetn, cmd.start, stat.busy)
endmodule
`default_nettype wire
